// ===== design/nad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nad_pkg - shared types and constants for the ascent direction block
// Sizes, register indexes, direction codes and the front/back request tag.
// ============================================================================
package nad_pkg;

   localparam int NAD_MAX_WIDTH   = 1024;
   localparam int NAD_PIXEL_BITS  = 8;
   localparam int NAD_QUEUE_DEPTH = 2;
   localparam int NAD_MAX_HEIGHT  = 1024;
   localparam int NAD_ROW_CAP     = 4096;
   localparam int NAD_ROW_BITS    = 13;
   localparam int NAD_SIZE_BITS   = 11;
   localparam int NAD_POS_BITS    = 10;
   localparam int NAD_DIR_BITS    = 4;
   localparam int NAD_CELLS       = 9;
   localparam int NAD_CENTER_CELL = 4;

   localparam logic [NAD_SIZE_BITS-1:0] NAD_WIDTH_RESET  = 11'd640;
   localparam logic [NAD_SIZE_BITS-1:0] NAD_HEIGHT_RESET = 11'd480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } nad_csr_index_type;

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } nad_command_type;

   localparam logic [NAD_DIR_BITS-1:0] DIR_CENTER     = 4'd0;
   localparam logic [NAD_DIR_BITS-1:0] DIR_UP         = 4'd1;
   localparam logic [NAD_DIR_BITS-1:0] DIR_UP_RIGHT   = 4'd2;
   localparam logic [NAD_DIR_BITS-1:0] DIR_RIGHT      = 4'd3;
   localparam logic [NAD_DIR_BITS-1:0] DIR_DOWN_RIGHT = 4'd4;
   localparam logic [NAD_DIR_BITS-1:0] DIR_DOWN       = 4'd5;
   localparam logic [NAD_DIR_BITS-1:0] DIR_DOWN_LEFT  = 4'd6;
   localparam logic [NAD_DIR_BITS-1:0] DIR_LEFT       = 4'd7;
   localparam logic [NAD_DIR_BITS-1:0] DIR_UP_LEFT    = 4'd8;

   typedef struct packed {
      logic [NAD_SIZE_BITS-1:0] image_width;
      logic [NAD_SIZE_BITS-1:0] image_height;
   } nad_cfg_type;

   // cell_ok bit k covers window cell k = 3*row + column, up-left first
   typedef struct packed {
      logic [NAD_CELLS-1:0]    cell_ok;
      logic [NAD_POS_BITS-1:0] row;
      logic [NAD_POS_BITS-1:0] column;
      logic                    last;
   } nad_tag_type;

   function automatic logic [NAD_DIR_BITS-1:0] nad_dir_code(input logic [3:0] slot);
      logic [NAD_DIR_BITS-1:0] code;
      case (slot)
         4'd0:    code = DIR_UP_LEFT;
         4'd1:    code = DIR_UP;
         4'd2:    code = DIR_UP_RIGHT;
         4'd3:    code = DIR_LEFT;
         4'd5:    code = DIR_RIGHT;
         4'd6:    code = DIR_DOWN_LEFT;
         4'd7:    code = DIR_DOWN;
         4'd8:    code = DIR_DOWN_RIGHT;
         default: code = DIR_CENTER;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== design/nad_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nad_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on
// a read of the address written in the same cycle).
// ============================================================================
module nad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/nad_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nad_front - request intake, line store and 3x3 window
// Classifies pixel and flush requests, keeps raster positions, shifts the
// window and queues one compare job per result with its edge mask.
// ============================================================================
module nad_front import nad_pkg::*; #(
   parameter int MAX_WIDTH  = NAD_MAX_WIDTH,
   parameter int PIXEL_BITS = NAD_PIXEL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  nad_cfg_type                     cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [7:0]                      req_pixel,
   input  logic                            q_ready,
   output logic                            q_push,
   output logic [NAD_CELLS*PIXEL_BITS-1:0] q_pixels,
   output nad_tag_type                     q_tag
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int LINE_BITS = 2 * PIXEL_BITS;
   localparam int WIN_BITS  = NAD_CELLS * PIXEL_BITS;

   logic [NAD_ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0]      in_col_ff, in_col_in;
   logic [NAD_POS_BITS-1:0]  emit_row_ff, emit_row_in;
   logic [COL_BITS-1:0]      emit_col_ff, emit_col_in;
   logic [WIN_BITS-1:0]      win_ff, win_in;
   logic                     fwd_valid_ff, fwd_valid_in;
   logic [LINE_BITS-1:0]     fwd_data_ff, fwd_data_in;

   logic [WID_BITS-1:0]      width_eff;
   logic [NAD_SIZE_BITS-1:0] height_eff;
   logic                     take, act, draining, emit, last;
   logic [PIXEL_BITS-1:0]    pix_new, top_pix, mid_pix;
   logic [LINE_BITS-1:0]     line_rd, line_wr, ram_rd_data;
   logic [COL_BITS-1:0]      ram_rd_addr;
   logic [2:0]               row_ok, col_ok;
   logic [NAD_CELLS-1:0]     cell_ok;

   // clamp the programmed sizes
   always_comb begin
      if (cfg.image_width == '0) begin
         width_eff = WID_BITS'(1);
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         width_eff = WID_BITS'(MAX_WIDTH);
      end else begin
         width_eff = WID_BITS'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         height_eff = NAD_SIZE_BITS'(1);
      end else if (cfg.image_height > NAD_SIZE_BITS'(NAD_MAX_HEIGHT)) begin
         height_eff = NAD_SIZE_BITS'(NAD_MAX_HEIGHT);
      end else begin
         height_eff = cfg.image_height;
      end
   end

   always_comb begin
      take     = req_valid && q_ready;
      draining = in_row_ff >= NAD_ROW_BITS'(height_eff);
      // a flush before the frame's last pixel is swallowed
      act      = take && !((req_command == CMD_FLUSH) && !draining);
      pix_new  = draining ? '0 : PIXEL_BITS'(req_pixel);

      line_rd  = fwd_valid_ff ? fwd_data_ff : ram_rd_data;
      top_pix  = line_rd[LINE_BITS-1:PIXEL_BITS];
      mid_pix  = line_rd[PIXEL_BITS-1:0];
      line_wr  = {mid_pix, pix_new};

      for (int r = 0; r < 3; r++) begin
         win_in[(r*3+0)*PIXEL_BITS +: PIXEL_BITS] = win_ff[(r*3+1)*PIXEL_BITS +: PIXEL_BITS];
         win_in[(r*3+1)*PIXEL_BITS +: PIXEL_BITS] = win_ff[(r*3+2)*PIXEL_BITS +: PIXEL_BITS];
      end
      win_in[2*PIXEL_BITS +: PIXEL_BITS] = top_pix;
      win_in[5*PIXEL_BITS +: PIXEL_BITS] = mid_pix;
      win_in[8*PIXEL_BITS +: PIXEL_BITS] = pix_new;

      emit = (in_row_ff >= NAD_ROW_BITS'(2))
          || ((in_row_ff == NAD_ROW_BITS'(1)) && (in_col_ff != '0));

      row_ok[0] = (emit_row_ff != '0) && (NAD_SIZE_BITS'(emit_row_ff) <= height_eff);
      row_ok[1] = NAD_SIZE_BITS'(emit_row_ff) < height_eff;
      row_ok[2] = (NAD_SIZE_BITS'(emit_row_ff) + NAD_SIZE_BITS'(1)) < height_eff;
      col_ok[0] = (emit_col_ff != '0) && (WID_BITS'(emit_col_ff) <= width_eff);
      col_ok[1] = WID_BITS'(emit_col_ff) < width_eff;
      col_ok[2] = (WID_BITS'(emit_col_ff) + WID_BITS'(1)) < width_eff;
      for (int k = 0; k < NAD_CELLS; k++) begin
         cell_ok[k] = row_ok[k/3] && col_ok[k%3];
      end

      last = ((NAD_SIZE_BITS'(emit_row_ff) + NAD_SIZE_BITS'(1)) >= height_eff)
          && ((WID_BITS'(emit_col_ff) + WID_BITS'(1)) >= width_eff);

      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      if (act) begin
         if ((WID_BITS'(in_col_ff) + WID_BITS'(1)) >= width_eff) begin
            in_col_in = '0;
            in_row_in = (in_row_ff >= NAD_ROW_BITS'(NAD_ROW_CAP))
                      ? NAD_ROW_BITS'(NAD_ROW_CAP) : in_row_ff + NAD_ROW_BITS'(1);
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
         if (emit) begin
            if (last) begin
               in_row_in   = '0;
               in_col_in   = '0;
               emit_row_in = '0;
               emit_col_in = '0;
            end else if ((WID_BITS'(emit_col_ff) + WID_BITS'(1)) >= width_eff) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + NAD_POS_BITS'(1);
            end else begin
               emit_col_in = emit_col_ff + COL_BITS'(1);
            end
         end
      end

      // read one column ahead; forward the write when it hits that column
      ram_rd_addr  = reset ? '0 : in_col_in;
      fwd_valid_in = act && (ram_rd_addr == in_col_ff);
      fwd_data_in  = line_wr;
   end

   nad_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (act),
      .wr_addr (in_col_ff),
      .wr_data (line_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         win_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         emit_row_ff  <= emit_row_in;
         emit_col_ff  <= emit_col_in;
         fwd_valid_ff <= fwd_valid_in;
         if (act) begin
            win_ff <= win_in;
         end
      end
      fwd_data_ff <= fwd_data_in;
   end

   assign req_ready = q_ready;
   assign q_push    = act && emit;
   assign q_pixels  = win_in;
   assign q_tag     = '{cell_ok: cell_ok,
                        row:     emit_row_ff,
                        column:  NAD_POS_BITS'(emit_col_ff),
                        last:    last};

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_tag.last) |=> (in_row_ff == '0 && in_col_ff == '0
                                  && emit_row_ff == '0 && emit_col_ff == '0))
      else $error("positions not cleared after frame end");

   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      (take && !act) |=> ($stable(in_row_ff) && $stable(in_col_ff) && $stable(win_ff)))
      else $error("swallowed flush changed state");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> $past(act))
      else $error("forward set without a line store write");

endmodule
`default_nettype wire

// ===== design/nad_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nad_queue - short FIFO between front and back
// Holds compare jobs so intake and result delivery stall independently.
// ============================================================================
module nad_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             ready,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign ready = count_ff != CNT_BITS'(DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (ready || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== design/nad_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nad_back - 3x3 compare and result register
// Scans the window in row order for the greatest unmasked neighbor above
// the center and holds the result until the response side takes it.
// ============================================================================
module nad_back import nad_pkg::*; #(
   parameter int PIXEL_BITS = NAD_PIXEL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  logic [NAD_CELLS*PIXEL_BITS-1:0] q_pixels,
   input  nad_tag_type                     q_tag,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic                            rsp_tlast
);

   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]             rsp_tdata_ff;
   logic                    rsp_tlast_ff;
   logic [PIXEL_BITS-1:0]   best;
   logic [NAD_DIR_BITS-1:0] dir;

   always_comb begin
      best = q_pixels[NAD_CENTER_CELL*PIXEL_BITS +: PIXEL_BITS];
      dir  = DIR_CENTER;
      for (int k = 0; k < NAD_CELLS; k++) begin
         if (q_tag.cell_ok[k] && (q_pixels[k*PIXEL_BITS +: PIXEL_BITS] > best)) begin
            best = q_pixels[k*PIXEL_BITS +: PIXEL_BITS];
            dir  = nad_dir_code(4'(k));
         end
      end
   end

   always_comb begin
      q_pop         = q_valid && (!rsp_tvalid_ff || rsp_tready);
      rsp_tvalid_in = rsp_tvalid_ff;
      if (q_pop) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (q_pop) begin
         rsp_tdata_ff <= {q_tag.column, q_tag.row, dir};
         rsp_tlast_ff <= q_tag.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[NAD_DIR_BITS-1:0] <= DIR_UP_LEFT))
      else $error("direction code out of range");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !rsp_tvalid_ff) |-> q_pop)
      else $error("queued job not taken into empty result register");

endmodule
`default_nettype wire

// ===== design/neighbourhood_ascent_direction_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// neighbourhood_ascent_direction_top - streamed 3x3 steepest ascent direction
// Raster pixels in, one direction code per pixel out, APB size registers.
// ============================================================================
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------
//  req_     | in  | req_tvalid / req_tready | tdata: pixel_value; tuser: command
//  rsp_     | out | rsp_tvalid / rsp_tready | tdata: direction, out_row, out_column
//           |     |                         | tlast: frame_last
//  csr_     | in  | psel / penable / pready | image_width @0x0, image_height @0x4
//
//  One request per clock sustained while the queue has room. The line store
//  read is issued one column ahead, so its single read port plus the 3x3
//  compare in the back set that. A pixel's result is caused by the request
//  image_width+1 places later and reaches rsp_ via queue and result register.
//  Reset (synchronous) clears positions, window and the queue, no clearing pass:
//  line store entries read before they are written only reach masked cells.
//  A stalled rsp_ side fills the two-entry queue, then drops req_tready.
//
module neighbourhood_ascent_direction_top import nad_pkg::*; #(
   parameter int MAX_WIDTH   = NAD_MAX_WIDTH,
   parameter int PIXEL_BITS  = NAD_PIXEL_BITS,
   parameter int QUEUE_DEPTH = NAD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  logic        req_tuser,   // [0] command (0 pixel, 1 flush)

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] direction, [13:4] out_row, [23:14] out_column
   output logic        rsp_tlast,   // frame_last

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int WIN_BITS   = NAD_CELLS * PIXEL_BITS;
   localparam int QUEUE_BITS = WIN_BITS + $bits(nad_tag_type);

   // size registers
   logic [NAD_SIZE_BITS-1:0] width_ff, width_in;
   logic [NAD_SIZE_BITS-1:0] height_ff, height_in;
   logic                     csr_write;
   nad_csr_index_type        csr_index;
   nad_cfg_type              cfg;

   // front to queue
   logic                     q_push, q_ready;
   logic [WIN_BITS-1:0]      push_pixels;
   nad_tag_type              push_tag;

   // queue to back
   logic                     q_valid, q_pop;
   logic [QUEUE_BITS-1:0]    q_head;
   nad_tag_type              head_tag;

   always_comb begin
      csr_write = csr_psel && csr_penable && csr_pwrite;
      csr_index = nad_csr_index_type'(csr_paddr[2]);
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_pwdata[NAD_SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_pwdata[NAD_SIZE_BITS-1:0];
            default: ;
         endcase
      end
      case (csr_index)
         CSR_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         CSR_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= NAD_WIDTH_RESET;
         height_ff <= NAD_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = '{image_width: width_ff, image_height: height_ff};

   // front: classify, line store, window, positions
   nad_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_pixel   (req_tdata),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_pixels    (push_pixels),
      .q_tag       (push_tag)
   );

   // compare jobs in flight between the two halves
   nad_queue #(
      .WIDTH (QUEUE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_tag, push_pixels}),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   assign head_tag = q_head[QUEUE_BITS-1:WIN_BITS];

   // back: 3x3 compare and result register
   nad_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pixels   (q_head[WIN_BITS-1:0]),
      .q_tag      (head_tag),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
